>>> src/rlrd_pkg.sv
// shared types and constants for the raster line run-length decoder
`default_nettype none

package rlrd_pkg;

    localparam int LINE_MAX   = 4096;
    localparam int PIXEL_MAX  = 8;
    localparam int ADDR_W     = $clog2(LINE_MAX);
    localparam int LB_W       = 13;
    localparam int LC_W       = 16;
    localparam int PB_W       = 4;
    localparam int FILL_W     = $clog2(LINE_MAX + 1);
    localparam int RUN_W      = 11;
    localparam int REP_W      = 9;
    localparam int ROWS_W     = 16;
    localparam int PIXIDX_W   = 4;
    localparam int K_W        = $clog2(PIXEL_MAX);
    localparam int HOLD_W     = 8 * PIXEL_MAX;
    localparam int TOTAL_W    = RUN_W + PB_W;
    localparam int SUM_W      = TOTAL_W + 1;
    localparam int LIT_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES = 2'd2;

    localparam logic [7:0]       LITERAL_OP_MIN = 8'd128;
    localparam logic [LIT_W-1:0] LITERAL_BASE   = 9'd257;

    typedef enum logic [1:0] {
        REQ_BYTE  = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_END   = 2'd2,
        REQ_START = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        PH_REPEAT   = 3'd0,
        PH_OP       = 3'd1,
        PH_PIXEL    = 3'd2,
        PH_LITERAL  = 3'd3,
        PH_EMIT     = 3'd4,
        PH_EMIT_END = 3'd5,
        PH_DONE     = 3'd6,
        PH_FILL     = 3'd7
    } phase_t;

endpackage

`default_nettype wire

>>> src/rlrd_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module rlrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> src/raster_line_rle_decoder_core.sv
// top level of the run-length raster line decoder with line repeat
// One request is taken per cycle when the m_ side is not stalled (coded byte,
// output tick, end of input or start page) and each request gives exactly one
// result on the m_ side, registered through the line store read and the output
// register. The decoded line lives in a 4096 x 8 synchronous ram; an output tick
// reads it at the emit pointer. A pixel run is written into the line store one
// byte per cycle, so the byte that completes a repeated pixel holds the input off
// until the clipped run is written; end of input in the middle of a line
// zero-pads the rest of the line the same way. All other requests run at one per
// cycle when the m_ side is not stalled. Register writes take effect at once and
// are meant for idle periods.
`default_nettype none

module raster_line_rle_decoder_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [rlrd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rlrd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [1:0]                      s_req_type,
    input  wire logic [7:0]                      s_in_byte,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_out_valid,
    output logic      [7:0]                      m_out_byte,
    output logic                                 m_line_end,
    output logic                                 m_page_end,
    output logic                                 m_refused
);

    import rlrd_pkg::*;

    logic [LB_W-1:0] line_bytes_reg;
    logic [LC_W-1:0] line_count_reg;
    logic [PB_W-1:0] pixel_bytes_reg;

    phase_t              phase_reg, phase_next;
    logic [FILL_W-1:0]   fill_count_reg, fill_count_next;
    logic [REP_W-1:0]    repeats_left_reg, repeats_left_next;
    logic [ROWS_W-1:0]   rows_emitted_reg, rows_emitted_next;
    logic [ADDR_W-1:0]   emit_index_reg, emit_index_next;
    logic [RUN_W-1:0]    run_left_reg, run_left_next;
    logic [HOLD_W-1:0]   pixel_hold_reg, pixel_hold_next;
    logic [PIXIDX_W-1:0] pixel_index_reg, pixel_index_next;
    logic [FILL_W-1:0]   fill_end_reg, fill_end_next;
    phase_t              fill_after_reg, fill_after_next;
    logic [PB_W-1:0]     fill_px_reg, fill_px_next;
    logic [K_W-1:0]      fill_k_reg, fill_k_next;

    logic s1_valid_reg;
    logic s1_out_valid_reg, s1_line_end_reg, s1_page_end_reg, s1_refused_reg;

    logic [FILL_W-1:0] stride;
    logic [LC_W-1:0]   height;
    logic [PB_W-1:0]   px;
    req_t              req;
    logic              s_fire, s1_adv, emitting;

    logic [ADDR_W:0]     emit_inc;
    logic                emit_last;
    logic [ROWS_W:0]     rows_inc;
    logic                page_last;
    logic [REP_W-1:0]    rep_dec;
    logic [PIXIDX_W-1:0] pix_idx_inc;
    logic                pix_done;
    logic [HOLD_W-1:0]   hold_ins;
    logic [TOTAL_W-1:0]  run_total;
    logic [SUM_W-1:0]    fill_sum;
    logic                fill_reach;
    logic [LIT_W-1:0]    lit_pixels;
    logic [LIT_W+PB_W-1:0] lit_len;
    logic                lit_wr;
    logic [FILL_W-1:0]   lit_count;
    logic [RUN_W-1:0]    lit_run;
    logic                fill_wr;
    logic [PIXIDX_W:0]   k_inc;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;

    logic res_out_valid, res_line_end, res_page_end, res_refused;

    // effective register values
    assign stride = (line_bytes_reg == '0) ? FILL_W'(1)
                  : (line_bytes_reg > FILL_W'(LINE_MAX)) ? FILL_W'(LINE_MAX)
                  : line_bytes_reg;
    assign height = (line_count_reg == '0) ? LC_W'(1) : line_count_reg;
    assign px     = (pixel_bytes_reg == '0) ? PB_W'(1)
                  : (pixel_bytes_reg > PB_W'(PIXEL_MAX)) ? PB_W'(PIXEL_MAX)
                  : pixel_bytes_reg;

    assign req      = req_t'(s_req_type);
    assign s1_adv   = !m_valid || m_ready;
    assign s_ready  = (phase_reg != PH_FILL) && (!s1_valid_reg || s1_adv);
    assign s_fire   = s_valid && s_ready;
    assign emitting = (phase_reg == PH_EMIT) || (phase_reg == PH_EMIT_END);

    assign emit_inc  = {1'b0, emit_index_reg} + 1'b1;
    assign emit_last = emit_inc >= stride;
    assign rows_inc  = {1'b0, rows_emitted_reg} + 1'b1;
    assign page_last = rows_inc >= {1'b0, height};
    assign rep_dec   = repeats_left_reg - REP_W'(repeats_left_reg != '0);

    assign pix_idx_inc = pixel_index_reg + 1'b1;
    assign pix_done    = pix_idx_inc >= px;
    assign hold_ins    = (pixel_index_reg < PIXIDX_W'(PIXEL_MAX))
                       ? (HOLD_W'(s_in_byte) << {pixel_index_reg[K_W-1:0], 3'b000})
                       : '0;
    assign run_total   = TOTAL_W'(run_left_reg) * TOTAL_W'(px);
    assign fill_sum    = SUM_W'(fill_count_reg) + SUM_W'(run_total);
    assign fill_reach  = fill_sum >= SUM_W'(stride);

    assign lit_pixels = LITERAL_BASE - {1'b0, s_in_byte};
    assign lit_len    = (LIT_W+PB_W)'(lit_pixels) * (LIT_W+PB_W)'(px);
    assign lit_wr     = fill_count_reg < stride;
    assign lit_count  = fill_count_reg + FILL_W'(lit_wr);
    assign lit_run    = run_left_reg - RUN_W'(run_left_reg != '0);

    assign fill_wr = fill_count_reg < fill_end_reg;
    assign k_inc   = {2'b00, fill_k_reg} + 1'b1;

    // next state
    always_comb begin
        phase_next        = phase_reg;
        fill_count_next   = fill_count_reg;
        repeats_left_next = repeats_left_reg;
        rows_emitted_next = rows_emitted_reg;
        emit_index_next   = emit_index_reg;
        run_left_next     = run_left_reg;
        pixel_hold_next   = pixel_hold_reg;
        pixel_index_next  = pixel_index_reg;
        fill_end_next     = fill_end_reg;
        fill_after_next   = fill_after_reg;
        fill_px_next      = fill_px_reg;
        fill_k_next       = fill_k_reg;
        if (phase_reg == PH_FILL) begin
            if (fill_wr) begin
                fill_count_next = fill_count_reg + 1'b1;
                fill_k_next     = (k_inc >= {1'b0, fill_px_reg}) ? '0 : k_inc[K_W-1:0];
            end else begin
                phase_next = fill_after_reg;
                if (fill_after_reg != PH_OP) begin
                    emit_index_next = '0;
                end
            end
        end else if (s_fire) begin
            unique case (req)
                REQ_BYTE: begin
                    unique case (phase_reg)
                        PH_REPEAT: begin
                            repeats_left_next = {1'b0, s_in_byte} + 1'b1;
                            fill_count_next   = '0;
                            phase_next        = PH_OP;
                        end
                        PH_OP: begin
                            if (s_in_byte < LITERAL_OP_MIN) begin
                                run_left_next    = RUN_W'(s_in_byte) + 1'b1;
                                pixel_hold_next  = '0;
                                pixel_index_next = '0;
                                phase_next       = PH_PIXEL;
                            end else begin
                                run_left_next = lit_len[RUN_W-1:0];
                                phase_next    = PH_LITERAL;
                            end
                        end
                        PH_PIXEL: begin
                            pixel_hold_next  = pixel_hold_reg | hold_ins;
                            pixel_index_next = pix_idx_inc;
                            if (pix_done) begin
                                fill_end_next   = fill_reach ? stride : fill_sum[FILL_W-1:0];
                                fill_after_next = fill_reach ? PH_EMIT : PH_OP;
                                fill_px_next    = px;
                                fill_k_next     = '0;
                                phase_next      = PH_FILL;
                            end
                        end
                        PH_LITERAL: begin
                            fill_count_next = lit_count;
                            run_left_next   = lit_run;
                            if (lit_count >= stride) begin
                                emit_index_next = '0;
                                phase_next      = PH_EMIT;
                            end else if (lit_run == '0) begin
                                phase_next = PH_OP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                REQ_TICK: begin
                    if (emitting) begin
                        if (emit_last) begin
                            rows_emitted_next = rows_inc[ROWS_W-1:0];
                            repeats_left_next = rep_dec;
                            emit_index_next   = '0;
                            if (page_last) begin
                                phase_next = PH_DONE;
                            end else if (rep_dec == '0) begin
                                fill_count_next = '0;
                                phase_next = (phase_reg == PH_EMIT_END) ? PH_DONE : PH_REPEAT;
                            end
                        end else begin
                            emit_index_next = emit_inc[ADDR_W-1:0];
                        end
                    end
                end
                REQ_END: begin
                    priority case (phase_reg)
                        PH_REPEAT: phase_next = PH_DONE;
                        PH_OP, PH_PIXEL, PH_LITERAL: begin
                            pixel_hold_next = '0;
                            fill_end_next   = stride;
                            fill_after_next = PH_EMIT_END;
                            fill_px_next    = px;
                            fill_k_next     = '0;
                            phase_next      = PH_FILL;
                        end
                        PH_EMIT: phase_next = PH_EMIT_END;
                        default: begin
                        end
                    endcase
                end
                REQ_START: begin
                    phase_next        = PH_REPEAT;
                    fill_count_next   = '0;
                    repeats_left_next = '0;
                    rows_emitted_next = '0;
                    emit_index_next   = '0;
                    run_left_next     = '0;
                    pixel_hold_next   = '0;
                    pixel_index_next  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // line store access and result fields
    always_comb begin
        ram_we        = 1'b0;
        ram_waddr     = fill_count_reg[ADDR_W-1:0];
        ram_wdata     = s_in_byte;
        ram_re        = 1'b0;
        ram_raddr     = emit_index_reg;
        res_out_valid = 1'b0;
        res_line_end  = 1'b0;
        res_page_end  = 1'b0;
        res_refused   = 1'b0;
        if (phase_reg == PH_FILL) begin
            ram_we    = fill_wr;
            ram_wdata = pixel_hold_reg[{fill_k_reg, 3'b000} +: 8];
        end else if (s_fire) begin
            if (req == REQ_BYTE) begin
                if (emitting || phase_reg == PH_DONE) begin
                    res_refused = 1'b1;
                end else if (phase_reg == PH_LITERAL) begin
                    ram_we = lit_wr;
                end
            end else if (req == REQ_TICK && emitting) begin
                ram_re        = 1'b1;
                res_out_valid = 1'b1;
                res_line_end  = emit_last;
                res_page_end  = emit_last && page_last;
            end
        end
    end

    rlrd_ram #(
        .WIDTH(8),
        .DEPTH(LINE_MAX)
    ) u_line_store (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_bytes_reg   <= LB_W'(1);
            line_count_reg   <= LC_W'(1);
            pixel_bytes_reg  <= PB_W'(1);
            phase_reg        <= PH_REPEAT;
            fill_count_reg   <= '0;
            repeats_left_reg <= '0;
            rows_emitted_reg <= '0;
            emit_index_reg   <= '0;
            run_left_reg     <= '0;
            pixel_hold_reg   <= '0;
            pixel_index_reg  <= '0;
            s1_valid_reg     <= 1'b0;
            m_valid          <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_LINE_BYTES:  line_bytes_reg  <= cfg_wdata[LB_W-1:0];
                    CFG_LINE_COUNT:  line_count_reg  <= cfg_wdata[LC_W-1:0];
                    CFG_PIXEL_BYTES: pixel_bytes_reg <= cfg_wdata[PB_W-1:0];
                    default: begin
                    end
                endcase
            end
            phase_reg        <= phase_next;
            fill_count_reg   <= fill_count_next;
            repeats_left_reg <= repeats_left_next;
            rows_emitted_reg <= rows_emitted_next;
            emit_index_reg   <= emit_index_next;
            run_left_reg     <= run_left_next;
            pixel_hold_reg   <= pixel_hold_next;
            pixel_index_reg  <= pixel_index_next;
            if (s_fire) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                m_valid <= s1_valid_reg;
            end
        end
    end

    // fill bookkeeping and transaction payload
    always_ff @(posedge aclk) begin
        fill_end_reg   <= fill_end_next;
        fill_after_reg <= fill_after_next;
        fill_px_reg    <= fill_px_next;
        fill_k_reg     <= fill_k_next;
        if (s_fire) begin
            s1_out_valid_reg <= res_out_valid;
            s1_line_end_reg  <= res_line_end;
            s1_page_end_reg  <= res_page_end;
            s1_refused_reg   <= res_refused;
        end
        if (s1_adv && s1_valid_reg) begin
            m_out_valid <= s1_out_valid_reg;
            m_out_byte  <= s1_out_valid_reg ? ram_rdata : 8'd0;
            m_line_end  <= s1_line_end_reg;
            m_page_end  <= s1_page_end_reg;
            m_refused   <= s1_refused_reg;
        end
    end

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("line store written and read in the same cycle");

    a_fill_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_FILL) |-> !s_fire && !ram_re)
        else $error("transaction accepted while a run is being written");

    a_page_end_on_line_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_page_end) |-> (m_line_end && m_out_valid && !m_refused))
        else $error("page end without a line end byte");

    a_fire_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> s1_valid_reg)
        else $error("accepted transaction lost before the output register");

    a_fill_lane_in_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_FILL) |-> ({1'b0, fill_k_reg} < fill_px_reg))
        else $error("pixel byte lane beyond the pixel width");

endmodule

`default_nettype wire

>>> tb/sv/raster_line_rle_decoder_core_tb.sv
// self-checking testbench for raster_line_rle_decoder_core: directed pages, then random coded pages
`timescale 1ns / 1ps

module raster_line_rle_decoder_core_tb;

    import rlrd_pkg::*;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       line_end;
        logic       page_end;
        logic       refused;
    } dec_result_t;

    logic                  aclk       = 1'b0;
    logic                  aresetn    = 1'b0;
    logic                  cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
    logic                  s_valid    = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_req_type = '0;
    logic [7:0]            s_in_byte  = '0;
    logic                  m_valid;
    logic                  m_ready    = 1'b0;
    logic                  m_out_valid;
    logic [7:0]            m_out_byte;
    logic                  m_line_end;
    logic                  m_page_end;
    logic                  m_refused;

    raster_line_rle_decoder_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_in_byte   (s_in_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_valid (m_out_valid),
        .m_out_byte  (m_out_byte),
        .m_line_end  (m_line_end),
        .m_page_end  (m_page_end),
        .m_refused   (m_refused)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // decoder state mirrored by the testbench
    logic [LB_W-1:0]     reg_line_bytes;
    logic [LC_W-1:0]     reg_line_count;
    logic [PB_W-1:0]     reg_pixel_bytes;
    phase_t              ph;
    logic [7:0]          line_mem [LINE_MAX];
    logic [FILL_W-1:0]   fill_cnt;
    logic [REP_W-1:0]    reps_left;
    logic [ROWS_W-1:0]   rows_done;
    logic [ADDR_W-1:0]   emit_ptr;
    logic [RUN_W-1:0]    run_cnt;
    logic [HOLD_W-1:0]   pix_hold;
    logic [PIXIDX_W-1:0] pix_idx;

    dec_result_t due_outputs[$];

    int fail_count   = 0;
    int items_sent   = 0;
    int n_results    = 0;
    int n_bytes      = 0;
    int n_line_ends  = 0;
    int n_page_ends  = 0;
    int n_refused    = 0;
    int n_reg_writes = 0;
    int burst_left   = 0;
    int rx_hold_left = 0;
    bit offer_up     = 1'b0;

    function automatic int unsigned stride_now();
        if (reg_line_bytes == 0) return 1;
        if (reg_line_bytes > LINE_MAX) return LINE_MAX;
        return reg_line_bytes;
    endfunction

    function automatic int unsigned height_now();
        return (reg_line_count == 0) ? 1 : reg_line_count;
    endfunction

    function automatic int unsigned px_now();
        if (reg_pixel_bytes == 0) return 1;
        if (reg_pixel_bytes > PIXEL_MAX) return PIXEL_MAX;
        return reg_pixel_bytes;
    endfunction

    function automatic void restart_page();
        ph        = PH_REPEAT;
        fill_cnt  = '0;
        reps_left = '0;
        rows_done = '0;
        emit_ptr  = '0;
        run_cnt   = '0;
        pix_hold  = '0;
        pix_idx   = '0;
    endfunction

    function automatic void check_line_full();
        if (fill_cnt >= stride_now()) begin
            emit_ptr = '0;
            ph = PH_EMIT;
        end
    endfunction

    function automatic void absorb_byte(logic [7:0] b);
        int unsigned stride, px, total, done_cnt, k;
        stride = stride_now();
        px = px_now();
        case (ph)
            PH_REPEAT: begin
                reps_left = REP_W'(b) + 1'b1;
                fill_cnt = '0;
                ph = PH_OP;
            end
            PH_OP: begin
                if (b < LITERAL_OP_MIN) begin
                    run_cnt = RUN_W'(b) + 1'b1;
                    pix_hold = '0;
                    pix_idx = '0;
                    ph = PH_PIXEL;
                end else begin
                    run_cnt = RUN_W'((LITERAL_BASE - b) * px);
                    ph = PH_LITERAL;
                end
            end
            PH_PIXEL: begin
                if (pix_idx < 8) pix_hold |= HOLD_W'(b) << (8 * pix_idx);
                pix_idx++;
                if (pix_idx >= px) begin
                    total = run_cnt * px;
                    done_cnt = 0;
                    k = 0;
                    while (done_cnt < total && fill_cnt < stride) begin
                        line_mem[fill_cnt[ADDR_W-1:0]] = pix_hold[8*k +: 8];
                        fill_cnt++;
                        done_cnt++;
                        k = (k + 1 >= px) ? 0 : k + 1;
                    end
                    ph = PH_OP;
                    check_line_full();
                end
            end
            PH_LITERAL: begin
                if (fill_cnt < stride) begin
                    line_mem[fill_cnt[ADDR_W-1:0]] = b;
                    fill_cnt++;
                end
                if (run_cnt > 0) run_cnt--;
                if (run_cnt == 0) ph = PH_OP;
                check_line_full();
            end
            default: ;
        endcase
    endfunction

    function automatic void finish_input();
        case (ph)
            PH_REPEAT: ph = PH_DONE;
            PH_OP, PH_PIXEL, PH_LITERAL: begin
                while (fill_cnt < stride_now()) begin
                    line_mem[fill_cnt[ADDR_W-1:0]] = 8'h00;
                    fill_cnt++;
                end
                emit_ptr = '0;
                ph = PH_EMIT_END;
            end
            PH_EMIT: ph = PH_EMIT_END;
            default: ;
        endcase
    endfunction

    function automatic dec_result_t decode_request(req_t rt, logic [7:0] b);
        dec_result_t res;
        bit emitting;
        res = '0;
        emitting = (ph == PH_EMIT) || (ph == PH_EMIT_END);
        case (rt)
            REQ_BYTE: begin
                if (emitting || ph == PH_DONE) res.refused = 1'b1;
                else absorb_byte(b);
            end
            REQ_TICK: begin
                if (emitting) begin
                    res.out_valid = 1'b1;
                    res.out_byte = line_mem[emit_ptr];
                    if (emit_ptr + 1 >= stride_now()) begin
                        res.line_end = 1'b1;
                        rows_done++;
                        if (reps_left > 0) reps_left--;
                        emit_ptr = '0;
                        if (rows_done >= height_now()) begin
                            res.page_end = 1'b1;
                            ph = PH_DONE;
                        end else if (reps_left == 0) begin
                            fill_cnt = '0;
                            ph = (ph == PH_EMIT_END) ? PH_DONE : PH_REPEAT;
                        end
                    end else begin
                        emit_ptr++;
                    end
                end
            end
            REQ_END: finish_input();
            default: restart_page();
        endcase
        return res;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : check_outputs
        dec_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_outputs.size() == 0) begin
                $error("result transaction arrived with none outstanding");
                fail_count++;
            end else begin
                want = due_outputs.pop_front();
                check_field("out_valid", 8'(want.out_valid), 8'(m_out_valid));
                check_field("out_byte", want.out_byte, m_out_byte);
                check_field("line_end", 8'(want.line_end), 8'(m_line_end));
                check_field("page_end", 8'(want.page_end), 8'(m_page_end));
                check_field("refused", 8'(want.refused), 8'(m_refused));
                n_results++;
                if (m_out_valid) n_bytes++;
                if (m_line_end) n_line_ends++;
                if (m_page_end) n_page_ends++;
                if (m_refused) n_refused++;
            end
        end
    end

    // receiver: ready pattern in modes, plus a long hold on request
    initial begin : rx_pattern
        int unsigned mode, mode_left;
        mode = 0;
        mode_left = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_left > 0) begin
                m_ready <= 1'b0;
                rx_hold_left--;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 1) == 1);
                    default: m_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    task automatic stop_sending();
        if (offer_up) begin
            s_valid <= 1'b0;
            offer_up = 1'b0;
        end
    endtask

    task automatic send_req(input req_t rt, input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) == 0) gap = 0;
            else gap = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 25 : 4);
            if (gap > 0) begin
                stop_sending();
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_req_type <= rt;
        s_in_byte <= b;
        offer_up = 1'b1;
        do @(posedge aclk); while (!s_ready);
        due_outputs.push_back(decode_request(rt, b));
        items_sent++;
    endtask

    task automatic wait_idle();
        stop_sending();
        while (due_outputs.size() != 0) @(posedge aclk);
        do @(posedge aclk); while (!s_ready);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_LINE_BYTES:  reg_line_bytes = val[LB_W-1:0];
            CFG_LINE_COUNT:  reg_line_count = val[LC_W-1:0];
            CFG_PIXEL_BYTES: reg_pixel_bytes = val[PB_W-1:0];
            default: ;
        endcase
        n_reg_writes++;
        @(posedge aclk);
    endtask

    task automatic pick_item(input bit noisy, output req_t rt, output logic [7:0] b);
        int unsigned roll, stride, px, height, lim;
        stride = stride_now();
        px = px_now();
        height = height_now();
        roll = $urandom_range(0, 99);
        rt = REQ_BYTE;
        b = 8'($urandom);
        if (noisy && roll < 5) begin
            rt = req_t'($urandom_range(0, 3));
        end else if (noisy && roll >= 97 && ph != PH_DONE) begin
            rt = REQ_END;
        end else begin
            case (ph)
                PH_REPEAT: begin
                    if (roll < 10 && stride * ((height < 256) ? height : 256) <= 300)
                        b = 8'd255;
                    else if (roll < 75) b = 8'($urandom_range(0, 2));
                    else b = 8'($urandom_range(0, 7));
                end
                PH_OP: begin
                    if (stride > 256) begin
                        b = 8'($urandom_range(64, 127));
                    end else if (roll < 50) begin
                        lim = stride / px + 1;
                        if (lim > 127) lim = 127;
                        b = (roll < 8) ? 8'd127 : 8'($urandom_range(0, lim));
                    end else begin
                        lim = stride / px + 2;
                        if (lim > 129) lim = 129;
                        b = 8'(LITERAL_BASE - ((roll >= 94) ? 129 : $urandom_range(2, lim)));
                    end
                end
                PH_EMIT, PH_EMIT_END: rt = REQ_TICK;
                PH_DONE: rt = REQ_START;
                default: ;
            endcase
        end
    endtask

    task automatic drive_page(input int unsigned cap, input bit noisy);
        int unsigned n;
        req_t rt;
        logic [7:0] b;
        n = 0;
        while (ph != PH_DONE && n < cap) begin
            pick_item(noisy, rt, b);
            send_req(rt, b);
            n++;
        end
    endtask

    task automatic test_reset_values();
        send_req(REQ_TICK, 8'h3C);
        send_req(REQ_BYTE, 8'd0);
        send_req(REQ_BYTE, 8'd0);
        send_req(REQ_BYTE, 8'hFF);
        send_req(REQ_BYTE, 8'h11);
        send_req(REQ_TICK, 8'h00);
        send_req(REQ_BYTE, 8'hC3);
        send_req(REQ_TICK, 8'hFF);
        wait_idle();
    endtask

    task automatic test_out_of_range_regs();
        write_reg(CFG_LINE_BYTES, 16'd0);
        write_reg(CFG_LINE_COUNT, 16'd0);
        write_reg(CFG_PIXEL_BYTES, 16'd0);
        send_req(REQ_START, 8'h00);
        send_req(REQ_END, 8'h00);
        send_req(REQ_START, 8'hAA);
        send_req(REQ_BYTE, 8'd1);
        send_req(REQ_BYTE, 8'd128);
        send_req(REQ_BYTE, 8'h5A);
        send_req(REQ_TICK, 8'h00);
        wait_idle();
    endtask

    task automatic test_clamped_width();
        write_reg(CFG_LINE_BYTES, 16'hFFFF);
        write_reg(CFG_LINE_COUNT, 16'hFFFF);
        write_reg(CFG_PIXEL_BYTES, 16'h000F);
        send_req(REQ_START, 8'h00);
        send_req(REQ_BYTE, 8'd0);
        send_req(REQ_BYTE, 8'd127);
        send_req(REQ_BYTE, 8'hA5);
        send_req(REQ_BYTE, 8'h5A);
        send_req(REQ_END, 8'h00);
        send_req(REQ_TICK, 8'h00);
        send_req(REQ_TICK, 8'h00);
        send_req(REQ_START, 8'h00);
        wait_idle();
    endtask

    task automatic test_end_while_emitting();
        write_reg(CFG_LINE_BYTES, 16'd2);
        write_reg(CFG_LINE_COUNT, 16'd3);
        write_reg(CFG_PIXEL_BYTES, 16'd1);
        send_req(REQ_START, 8'h00);
        send_req(REQ_BYTE, 8'd1);
        send_req(REQ_BYTE, 8'd255);
        send_req(REQ_BYTE, 8'h80);
        send_req(REQ_BYTE, 8'h01);
        send_req(REQ_END, 8'h00);
        repeat (4) send_req(REQ_TICK, 8'h00);
        wait_idle();
    endtask

    // fill the widest line, read its head, then abandon the page
    task automatic test_widest_line();
        write_reg(CFG_LINE_BYTES, 16'd4096);
        write_reg(CFG_LINE_COUNT, 16'd1);
        write_reg(CFG_PIXEL_BYTES, 16'd8);
        send_req(REQ_START, 8'($urandom));
        drive_page(600, 1'b0);
        send_req(REQ_START, 8'($urandom));
        wait_idle();
    endtask

    task automatic test_output_stall();
        write_reg(CFG_LINE_BYTES, 16'd6);
        write_reg(CFG_LINE_COUNT, 16'd200);
        write_reg(CFG_PIXEL_BYTES, 16'd2);
        rx_hold_left = 300;
        send_req(REQ_START, 8'($urandom));
        drive_page(120, 1'b1);
        wait_idle();
    endtask

    task automatic set_random_regs();
        logic [CFG_DATA_W-1:0] lb, lc, pb;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) lb = CFG_DATA_W'($urandom_range(1, 8));
        else if (roll < 85) lb = CFG_DATA_W'($urandom_range(9, 64));
        else if (roll < 93) lb = '0;
        else lb = {3'($urandom), 13'($urandom_range(1, 12))};
        roll = $urandom_range(0, 99);
        if (roll < 50) lc = CFG_DATA_W'($urandom_range(1, 4));
        else if (roll < 80) lc = CFG_DATA_W'($urandom_range(5, 40));
        else if (roll < 90) lc = '0;
        else lc = 16'hFFFF;
        roll = $urandom_range(0, 99);
        if (roll < 60) pb = CFG_DATA_W'($urandom_range(1, 3));
        else if (roll < 90) pb = CFG_DATA_W'($urandom_range(0, 15));
        else pb = {12'($urandom), 4'($urandom_range(0, 15))};
        write_reg(CFG_LINE_BYTES, lb);
        write_reg(CFG_LINE_COUNT, lc);
        write_reg(CFG_PIXEL_BYTES, pb);
    endtask

    // mid-page change; the width never grows under a line being emitted
    task automatic tweak_reg();
        int unsigned which;
        which = $urandom_range(0, 2);
        case (which)
            0: begin
                if (ph == PH_EMIT || ph == PH_EMIT_END)
                    write_reg(CFG_LINE_BYTES, CFG_DATA_W'($urandom_range(1, stride_now())));
                else
                    write_reg(CFG_LINE_BYTES, CFG_DATA_W'($urandom_range(0, 64)));
            end
            1: write_reg(CFG_LINE_COUNT, CFG_DATA_W'($urandom_range(0, 6)));
            default: write_reg(CFG_PIXEL_BYTES, CFG_DATA_W'($urandom_range(0, 15)));
        endcase
    endtask

    task automatic test_random_pages();
        while (items_sent < 1900) begin
            wait_idle();
            set_random_regs();
            repeat ($urandom_range(1, 3)) begin
                send_req(REQ_START, 8'($urandom));
                drive_page($urandom_range(30, 300), 1'b1);
                if (ph != PH_DONE && $urandom_range(0, 3) == 0) begin
                    wait_idle();
                    tweak_reg();
                    drive_page(300, 1'b1);
                end
            end
        end
        wait_idle();
    endtask

    initial begin
        reg_line_bytes = LB_W'(1);
        reg_line_count = LC_W'(1);
        reg_pixel_bytes = PB_W'(1);
        restart_page();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_out_of_range_regs();
        test_clamped_width();
        test_end_while_emitting();
        test_widest_line();
        test_output_stall();
        test_random_pages();
        stop_sending();
        while (due_outputs.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        $display("run: %0d requests, %0d results checked, %0d register writes",
                 items_sent, n_results, n_reg_writes);
        $display("run: %0d decoded bytes, %0d line ends, %0d page ends, %0d refused bytes",
                 n_bytes, n_line_ends, n_page_ends, n_refused);
        if (fail_count == 0) begin
            $display("raster_line_rle_decoder_core_tb passed");
        end else begin
            $display("raster_line_rle_decoder_core_tb failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d results outstanding", due_outputs.size());
        $display("raster_line_rle_decoder_core_tb failed");
        $finish;
    end

endmodule
